// ===== hw/rtl/mjdc_pkg.sv =====
// Shared types, constants and helper functions for the MJD/BCD time stamp converter.
// No dependencies; every other file refers to it by scoped names.
package mjdc_pkg;

	localparam int NSTAGE = 6;

	// MJD plus the March shift, reduced by four whole 400-year cycles
	localparam logic [17:0] MJD_TO_IN400 = 18'd94493;
	localparam logic [17:0] DAYS_400Y    = 18'd146097;
	localparam logic [17:0] DAYS_100Y    = 18'd36524;
	localparam logic [15:0] DAYS_4Y      = 16'd1461;
	localparam logic [10:0] DAYS_1Y      = 11'd365;
	localparam logic [8:0]  DOY_LEAP     = 9'd365;
	localparam logic [2:0]  LAST_CYCLE   = 3'd4;

	// quad estimate: in100 * 2870 >> 22, low by at most one
	localparam logic [11:0] QUAD_RECIP = 12'd2870;
	localparam int          QUAD_SHIFT = 22;

	localparam logic [8:0] MON5_DAYS  = 9'd153;
	localparam logic [7:0] MON2_DAYS  = 8'd61;
	localparam logic [5:0] MON1_DAYS  = 6'd31;
	localparam logic [3:0] MONTHS     = 4'd12;

	localparam logic [10:0] YEAR_BASE_LO = 11'd1600;
	localparam logic [10:0] YEAR_BASE_HI = 11'd2000;

	localparam logic [16:0] WDAY_OFFSET = 17'd3;

	typedef struct packed {
		logic [15:0] mjd;
		logic [7:0]  hour_bcd;
		logic [7:0]  minute_bcd;
		logic [7:0]  second_bcd;
	} ts_t;

	typedef struct packed {
		logic [10:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [2:0]  weekday;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  second;
	} cal_t;

	typedef struct packed {
		logic [NSTAGE-1:0] load;
	} pipe_ctrl_t;

	typedef struct packed {
		logic        q400_hi;
		logic [2:0]  cent;
		logic [4:0]  quad;
		logic [10:0] in4;
	} era_t;

	typedef struct packed {
		logic [10:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
	} date_t;

	typedef struct packed {
		logic [2:0] weekday;
		logic [7:0] hour;
		logic [7:0] minute;
		logic [7:0] second;
	} tlane_t;

	function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
		logic [7:0] tens;
		tens = {4'b0, b[7:4]};
		return (tens << 3) + (tens << 1) + {4'b0, b[3:0]};
	endfunction

	// (mjd + 3) mod 7 by folding octal digits (8 == 1 mod 7)
	function automatic logic [2:0] weekday_of(input logic [15:0] mjd);
		logic [16:0] y;
		logic [5:0]  s;
		logic [3:0]  t;
		logic [2:0]  u;
		y = {1'b0, mjd} + WDAY_OFFSET;
		s = 6'(y[2:0]) + 6'(y[5:3]) + 6'(y[8:6]) + 6'(y[11:9]) + 6'(y[14:12])
			+ 6'(y[16:15]);
		t = 4'(s[2:0]) + 4'(s[5:3]);
		u = t[2:0] + 3'(t[3]);
		return (u == 3'd7) ? 3'd0 : u;
	endfunction

endpackage

// ===== hw/rtl/mjd_bcd_time_to_calendar.sv =====
// Broadcast time stamp converter: one ts beat (16-bit MJD plus BCD hour, minute,
// second) gives one cal beat with Gregorian year, month, day, weekday (Sunday = 0)
// and binary time. Fixed six-stage pipeline: a beat is accepted every clock
// while cal_stall stays low, and its result passes through the six register
// stages of the calendar split (400/100-year cycles, the 4-year reciprocal
// estimate and its correction, year and day of year, month).
// BCD digits are not range checked: each byte maps to tens * 10 + ones (max 165).
// Depends on mjdc_pkg, mjdc_pipe_ctrl, mjdc_era_split, mjdc_year_month,
// mjdc_time_lane.
module mjd_bcd_time_to_calendar (
	input  logic           clk,
	input  logic           arst_n,
	// time stamp channel
	input  logic           ts_valid,
	output logic           ts_stall,
	input  mjdc_pkg::ts_t  ts,
	// calendar result channel
	output logic           cal_valid,
	input  logic           cal_stall,
	output mjdc_pkg::cal_t cal
);

	mjdc_pkg::pipe_ctrl_t ctrl;
	mjdc_pkg::era_t       era;
	mjdc_pkg::date_t      date;
	mjdc_pkg::tlane_t     lane;

	// Valid bits per stage; stall ripples back only through full stages,
	// so bubbles are squeezed out while the output is held.
	mjdc_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.ts_valid  (ts_valid),
		.cal_stall (cal_stall),
		.ts_stall  (ts_stall),
		.cal_valid (cal_valid),
		.ctrl      (ctrl)
	);

	// Stages 1-4: day index inside the 400-year cycle, century, 4-year block.
	mjdc_era_split u_era (
		.clk  (clk),
		.ctrl (ctrl),
		.mjd  (ts.mjd),
		.era  (era)
	);

	// Stages 5-6: March-based year and day of year, then month and day,
	// with January/February folded into the next calendar year.
	mjdc_year_month u_ym (
		.clk  (clk),
		.ctrl (ctrl),
		.era  (era),
		.date (date)
	);

	// Weekday and time fields are computed in stage 1 and ride along.
	mjdc_time_lane u_lane (
		.clk  (clk),
		.ctrl (ctrl),
		.ts   (ts),
		.lane (lane)
	);

	assign cal.year         = date.year;
	assign cal.month        = date.month;
	assign cal.day_of_month = date.day_of_month;
	assign cal.weekday      = lane.weekday;
	assign cal.hour         = lane.hour;
	assign cal.minute       = lane.minute;
	assign cal.second       = lane.second;

	// Input back-pressure only when every stage holds a beat and output is stalled.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		ts_stall |-> (cal_valid && cal_stall))
		else $error("ts_stall raised with a free pipeline slot");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid |-> (cal.month >= 4'd1 && cal.month <= 4'd12
			&& cal.day_of_month != 5'd0))
		else $error("month or day out of range");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid |-> (cal.year >= 11'd1858 && cal.year <= 11'd2039))
		else $error("year out of range");

	a_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		cal_valid |-> (cal.weekday <= 3'd6))
		else $error("weekday out of range");

endmodule

// ===== hw/rtl/mjdc_pipe_ctrl.sv =====
// Valid bits and load enables for the six-stage converter pipeline.
// Depends on mjdc_pkg.
module mjdc_pipe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ts_valid,
	input  logic                cal_stall,
	output logic                ts_stall,
	output logic                cal_valid,
	output mjdc_pkg::pipe_ctrl_t ctrl
);

	logic [mjdc_pkg::NSTAGE-1:0] valid_q;
	logic [mjdc_pkg::NSTAGE-1:0] load;

	// a stage loads when empty or when the stage after it moves
	always_comb begin
		load[mjdc_pkg::NSTAGE-1] = !valid_q[mjdc_pkg::NSTAGE-1] || !cal_stall;
		for (int k = mjdc_pkg::NSTAGE - 2; k >= 0; k--) begin
			load[k] = !valid_q[k] || load[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[0]) begin
				valid_q[0] <= ts_valid;
			end
			for (int k = 1; k < mjdc_pkg::NSTAGE; k++) begin
				if (load[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign ctrl.load = load;
	assign ts_stall  = !load[0];
	assign cal_valid = valid_q[mjdc_pkg::NSTAGE-1];

endmodule

// ===== hw/rtl/mjdc_era_split.sv =====
// Stages 1-4: day count split into 400-year, 100-year and 4-year cycles.
// Depends on mjdc_pkg.
module mjdc_era_split (
	input  logic                 clk,
	input  mjdc_pkg::pipe_ctrl_t ctrl,
	input  logic [15:0]          mjd,
	output mjdc_pkg::era_t       era
);

	// stage 1
	logic [17:0] x;
	logic        hi;
	logic [17:0] in400_s1;
	logic        hi_s1;

	always_comb begin
		x  = {2'b0, mjd} + mjdc_pkg::MJD_TO_IN400;
		hi = (x >= mjdc_pkg::DAYS_400Y);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[0]) begin
			in400_s1 <= hi ? x - mjdc_pkg::DAYS_400Y : x;
			hi_s1    <= hi;
		end
	end

	// stage 2: century, 0..4 (4 only on the leap day closing the cycle)
	logic [2:0]  cent;
	logic [17:0] cent_off;
	logic [17:0] in100_w;
	logic [2:0]  cent_s2;
	logic [15:0] in100_s2;
	logic        hi_s2;

	always_comb begin
		if (in400_s1 >= 18'(4 * 36524)) begin
			cent = mjdc_pkg::LAST_CYCLE; cent_off = 18'(4 * 36524);
		end else if (in400_s1 >= 18'(3 * 36524)) begin
			cent = 3'd3; cent_off = 18'(3 * 36524);
		end else if (in400_s1 >= 18'(2 * 36524)) begin
			cent = 3'd2; cent_off = 18'(2 * 36524);
		end else if (in400_s1 >= mjdc_pkg::DAYS_100Y) begin
			cent = 3'd1; cent_off = mjdc_pkg::DAYS_100Y;
		end else begin
			cent = 3'd0; cent_off = '0;
		end
		in100_w = in400_s1 - cent_off;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[1]) begin
			cent_s2  <= cent;
			in100_s2 <= in100_w[15:0];
			hi_s2    <= hi_s1;
		end
	end

	// stage 3: reciprocal estimate of in100 / 1461
	logic [27:0] recip_prod;
	logic [4:0]  qest_s3;
	logic [15:0] in100_s3;
	logic [2:0]  cent_s3;
	logic        hi_s3;

	assign recip_prod = {12'b0, in100_s2} * {16'b0, mjdc_pkg::QUAD_RECIP};

	always_ff @(posedge clk) begin
		if (ctrl.load[2]) begin
			qest_s3  <= recip_prod[mjdc_pkg::QUAD_SHIFT +: 5];
			in100_s3 <= in100_s2;
			cent_s3  <= cent_s2;
			hi_s3    <= hi_s2;
		end
	end

	// stage 4: remainder and one-step correction
	logic [15:0] back;
	logic [15:0] rem;
	logic        fix;

	always_comb begin
		back = 16'({11'b0, qest_s3} * mjdc_pkg::DAYS_4Y);
		rem  = in100_s3 - back;
		fix  = (rem >= mjdc_pkg::DAYS_4Y);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[3]) begin
			era.q400_hi <= hi_s3;
			era.cent    <= cent_s3;
			era.quad    <= qest_s3 + 5'(fix);
			era.in4     <= fix ? 11'(rem - mjdc_pkg::DAYS_4Y) : rem[10:0];
		end
	end

endmodule

// ===== hw/rtl/mjdc_year_month.sv =====
// Stages 5-6: year within the 4-year cycle, day of year, month and day.
// Depends on mjdc_pkg.
module mjdc_year_month (
	input  logic                 clk,
	input  mjdc_pkg::pipe_ctrl_t ctrl,
	input  mjdc_pkg::era_t       era,
	output mjdc_pkg::date_t      date
);

	// stage 5
	logic [2:0]  yr;
	logic [10:0] yr_off;
	logic [10:0] c100;
	logic [10:0] base;
	logic        last_c;
	logic        last_y;
	logic [8:0]  doy_s5;
	logic [10:0] year_s5;

	always_comb begin
		if (era.in4 >= 11'(4 * 365)) begin
			yr = mjdc_pkg::LAST_CYCLE; yr_off = 11'(4 * 365);
		end else if (era.in4 >= 11'(3 * 365)) begin
			yr = 3'd3; yr_off = 11'(3 * 365);
		end else if (era.in4 >= 11'(2 * 365)) begin
			yr = 3'd2; yr_off = 11'(2 * 365);
		end else if (era.in4 >= mjdc_pkg::DAYS_1Y) begin
			yr = 3'd1; yr_off = mjdc_pkg::DAYS_1Y;
		end else begin
			yr = 3'd0; yr_off = '0;
		end
		case (era.cent)
			3'd1:    c100 = 11'd100;
			3'd2:    c100 = 11'd200;
			3'd3:    c100 = 11'd300;
			3'd4:    c100 = 11'd400;
			default: c100 = 11'd0;
		endcase
		last_c = (era.cent == mjdc_pkg::LAST_CYCLE);
		last_y = (yr == mjdc_pkg::LAST_CYCLE);
		base   = era.q400_hi ? mjdc_pkg::YEAR_BASE_HI : mjdc_pkg::YEAR_BASE_LO;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[4]) begin
			// both leap-day folds land on day 365 of the March year
			doy_s5  <= (last_c || last_y) ? mjdc_pkg::DOY_LEAP : 9'(era.in4 - yr_off);
			year_s5 <= base + c100 + {4'b0, era.quad, 2'b0} + {8'b0, yr}
				- {10'b0, last_c} - {10'b0, last_y};
		end
	end

	// stage 6: 153/61/31-day month groups
	logic [8:0] r0;
	logic [7:0] r1;
	logic [5:0] r2;
	logic [3:0] mon_g;
	logic [3:0] mon_h;
	logic       k;
	logic [3:0] mon_raw;
	logic       wrap;

	always_comb begin
		if (doy_s5 >= 9'(2 * 153)) begin
			mon_g = 4'd10; r0 = doy_s5 - 9'(2 * 153);
		end else if (doy_s5 >= mjdc_pkg::MON5_DAYS) begin
			mon_g = 4'd5;  r0 = doy_s5 - mjdc_pkg::MON5_DAYS;
		end else begin
			mon_g = 4'd0;  r0 = doy_s5;
		end
		r1 = r0[7:0];
		if (r1 >= 8'(2 * 61)) begin
			mon_h = 4'd4; r2 = 6'(r1 - 8'(2 * 61));
		end else if (r1 >= mjdc_pkg::MON2_DAYS) begin
			mon_h = 4'd2; r2 = 6'(r1 - mjdc_pkg::MON2_DAYS);
		end else begin
			mon_h = 4'd0; r2 = r1[5:0];
		end
		k       = (r2 >= mjdc_pkg::MON1_DAYS);
		mon_raw = mon_g + mon_h + 4'(k) + 4'd3;
		wrap    = (mon_raw > mjdc_pkg::MONTHS);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[5]) begin
			date.year         <= year_s5 + 11'(wrap);
			date.month        <= wrap ? mon_raw - mjdc_pkg::MONTHS : mon_raw;
			date.day_of_month <= 5'(k ? r2 - mjdc_pkg::MON1_DAYS : r2) + 5'd1;
		end
	end

endmodule

// ===== hw/rtl/mjdc_time_lane.sv =====
// Weekday and BCD-to-binary time fields, delayed to match the date stages.
// Depends on mjdc_pkg.
module mjdc_time_lane (
	input  logic                 clk,
	input  mjdc_pkg::pipe_ctrl_t ctrl,
	input  mjdc_pkg::ts_t        ts,
	output mjdc_pkg::tlane_t     lane
);

	mjdc_pkg::tlane_t lane_s1, lane_s2, lane_s3, lane_s4, lane_s5, lane_s6;

	always_ff @(posedge clk) begin
		if (ctrl.load[0]) begin
			lane_s1.weekday <= mjdc_pkg::weekday_of(ts.mjd);
			lane_s1.hour    <= mjdc_pkg::bcd_to_bin(ts.hour_bcd);
			lane_s1.minute  <= mjdc_pkg::bcd_to_bin(ts.minute_bcd);
			lane_s1.second  <= mjdc_pkg::bcd_to_bin(ts.second_bcd);
		end
		if (ctrl.load[1]) begin
			lane_s2 <= lane_s1;
		end
		if (ctrl.load[2]) begin
			lane_s3 <= lane_s2;
		end
		if (ctrl.load[3]) begin
			lane_s4 <= lane_s3;
		end
		if (ctrl.load[4]) begin
			lane_s5 <= lane_s4;
		end
		if (ctrl.load[5]) begin
			lane_s6 <= lane_s5;
		end
	end

	assign lane = lane_s6;

endmodule
